// ===== rtl/ttlp_pkg.sv =====
// Shared types, constants and helpers for the touch tap / long-press detector.
// Holds the item structs, state encodings and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ttlp_pkg;

  localparam int RAW_W   = 12;  // raw panel reading width
  localparam int SUM_W   = 14;  // sum of up to three raw readings
  localparam int CNT_W   = 2;   // number of valid samples, 0..3
  localparam int PIX_W   = 11;  // screen pixel coordinate
  localparam int PROD_W  = 24;  // magnitude of (raw - min) * size
  localparam int CYC_W   = 4;   // bit counter of the serial units
  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT    = 3'd6;

  localparam logic [PIX_W-1:0] PIX_MAX         = 11'd2047;
  localparam logic [PIX_W-1:0] TAP_MOVE_LIMIT  = 11'd40;
  localparam logic [PIX_W-1:0] LONG_MOVE_LIMIT = 11'd20;

  typedef enum logic [1:0] {
    GEST_NONE = 2'd0,
    GEST_TAP  = 2'd1,
    GEST_LONG = 2'd2
  } gesture_t;

  typedef enum logic [2:0] {
    AX_IDLE,
    AX_AVG,
    AX_PREP,
    AX_MUL,
    AX_CHK,
    AX_DIV,
    AX_DONE
  } ax_state_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MAP,
    ENG_CLS,
    ENG_PUSH
  } eng_state_t;

  typedef struct packed {
    logic             first_touched;
    logic             sample0_valid;
    logic [RAW_W-1:0] sample0_x;
    logic [RAW_W-1:0] sample0_y;
    logic             sample1_valid;
    logic [RAW_W-1:0] sample1_x;
    logic [RAW_W-1:0] sample1_y;
    logic             sample2_valid;
    logic [RAW_W-1:0] sample2_x;
    logic [RAW_W-1:0] sample2_y;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    gesture_t         gesture;
    logic [PIX_W-1:0] tap_x;
    logic [PIX_W-1:0] tap_y;
  } out_item_t;

  function automatic logic [PIX_W-1:0] pix_abs_diff(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/ttlp_axis_map.sv =====
// One axis of the coordinate mapper: serial average, serial multiply by the
// screen size and serial divide by the calibrated raw span, then clamp.
// Depends on ttlp_pkg.
`timescale 1ns / 1ps

module ttlp_axis_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ttlp_pkg::SUM_W-1:0]  sum,
  input  logic [ttlp_pkg::CNT_W-1:0]  cnt,
  input  logic [ttlp_pkg::RAW_W-1:0]  raw_lo,
  input  logic [ttlp_pkg::RAW_W-1:0]  raw_hi,
  input  logic [ttlp_pkg::RAW_W-1:0]  size,
  output logic [ttlp_pkg::PIX_W-1:0]  pix,
  output logic                        done
);
  import ttlp_pkg::*;

  ax_state_t            state_r, state_nxt;
  logic [CYC_W-1:0]     cyc_r, cyc_nxt;
  logic [RAW_W-1:0]     sr_r, sr_nxt;       // dividend bits out, quotient bits in
  logic [CNT_W-1:0]     rema_r, rema_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [RAW_W-1:0]     mag_r, mag_nxt;
  logic [RAW_W-1:0]     msr_r, msr_nxt;     // multiplier bits, MSB first
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic                 dneg_r, dneg_nxt;
  logic [RAW_W-1:0]     dmag_r, dmag_nxt;
  logic [RAW_W-1:0]     rem_r, rem_nxt;
  logic [PIX_W-1:0]     pix_r, pix_nxt;
  logic                 fix_r, fix_nxt;     // pixel already settled before the divide

  logic [CNT_W:0]       t_avg;
  logic [RAW_W:0]       t_div;
  logic [RAW_W:0]       diff;
  logic [RAW_W:0]       span;
  logic [PIX_W-1:0]     top;
  logic [PIX_W-1:0]     q_new;
  logic                 qbit;

  // Largest pixel value for this axis; a size of zero maps everything to 0.
  always_comb begin
    if (size == '0) begin
      top = '0;
    end else if (size > {1'b0, PIX_MAX} + 12'd1) begin
      top = PIX_MAX;
    end else begin
      top = PIX_W'(size - 12'd1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cyc_nxt   = cyc_r;
    sr_nxt    = sr_r;
    rema_nxt  = rema_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    msr_nxt   = msr_r;
    acc_nxt   = acc_r;
    dneg_nxt  = dneg_r;
    dmag_nxt  = dmag_r;
    rem_nxt   = rem_r;
    pix_nxt   = pix_r;
    fix_nxt   = fix_r;
    qbit      = 1'b0;
    t_avg     = {rema_r, sr_r[RAW_W-1]};
    t_div     = {rem_r, acc_r[PIX_W-1]};
    diff      = {1'b0, sr_r} - {1'b0, raw_lo};
    span      = {1'b0, raw_hi} - {1'b0, raw_lo};
    q_new     = '0;
    unique case (state_r)
      AX_IDLE: begin
        if (start) begin
          // The top bits of the sum are below the count, so they seed the remainder.
          sr_nxt    = sum[RAW_W-1:0];
          rema_nxt  = sum[SUM_W-1:RAW_W];
          cnt_nxt   = cnt;
          cyc_nxt   = '0;
          state_nxt = AX_AVG;
        end
      end
      AX_AVG: begin
        if (t_avg >= {1'b0, cnt_r}) begin
          rema_nxt = CNT_W'(t_avg - {1'b0, cnt_r});
          qbit     = 1'b1;
        end else begin
          rema_nxt = t_avg[CNT_W-1:0];
        end
        sr_nxt  = {sr_r[RAW_W-2:0], qbit};
        cyc_nxt = cyc_r + 1'b1;
        if (cyc_r == CYC_W'(RAW_W - 1)) begin
          state_nxt = AX_PREP;
        end
      end
      AX_PREP: begin
        neg_nxt   = diff[RAW_W];
        mag_nxt   = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
        dneg_nxt  = span[RAW_W];
        dmag_nxt  = span[RAW_W] ? RAW_W'(-span) : span[RAW_W-1:0];
        msr_nxt   = size;
        acc_nxt   = '0;
        cyc_nxt   = '0;
        state_nxt = AX_MUL;
      end
      AX_MUL: begin
        acc_nxt = {acc_r[PROD_W-2:0], 1'b0}
                + (msr_r[RAW_W-1] ? {{(PROD_W-RAW_W){1'b0}}, mag_r} : '0);
        msr_nxt = {msr_r[RAW_W-2:0], 1'b0};
        cyc_nxt = cyc_r + 1'b1;
        if (cyc_r == CYC_W'(RAW_W - 1)) begin
          state_nxt = AX_CHK;
        end
      end
      AX_CHK: begin
        // A zero span, a zero product or a negative quotient all clamp to 0.
        // Settled cases still run the divide, so both axes finish together.
        if (dmag_r == '0 || acc_r == '0 || neg_r != dneg_r) begin
          pix_nxt = '0;
          fix_nxt = 1'b1;
        end else if (acc_r >= {1'b0, dmag_r, {PIX_W{1'b0}}}) begin
          pix_nxt = top;
          fix_nxt = 1'b1;
        end else begin
          fix_nxt = 1'b0;
        end
        rem_nxt   = acc_r[PROD_W-2:PIX_W];
        cyc_nxt   = '0;
        state_nxt = AX_DIV;
      end
      AX_DIV: begin
        if (t_div >= {1'b0, dmag_r}) begin
          rem_nxt = RAW_W'(t_div - {1'b0, dmag_r});
          qbit    = 1'b1;
        end else begin
          rem_nxt = t_div[RAW_W-1:0];
        end
        q_new   = {acc_r[PIX_W-2:0], qbit};
        acc_nxt = {acc_r[PROD_W-1:PIX_W], q_new};
        cyc_nxt = cyc_r + 1'b1;
        if (cyc_r == CYC_W'(PIX_W - 1)) begin
          if (!fix_r) begin
            pix_nxt = (q_new > top) ? top : q_new;
          end
          state_nxt = AX_DONE;
        end
      end
      AX_DONE: begin
        state_nxt = AX_IDLE;
      end
      default: begin
        state_nxt = AX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cyc_r  <= cyc_nxt;
    sr_r   <= sr_nxt;
    rema_r <= rema_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    msr_r  <= msr_nxt;
    acc_r  <= acc_nxt;
    dneg_r <= dneg_nxt;
    dmag_r <= dmag_nxt;
    rem_r  <= rem_nxt;
    pix_r  <= pix_nxt;
    fix_r  <= fix_nxt;
  end

  assign pix  = pix_r;
  assign done = (state_r == AX_DONE);

endmodule

// ===== rtl/touch_tap_long_press_detector.sv =====
// Top level of the touch tap / long-press detector: poll intake, calibration
// registers, gesture state machine and output register.
// Depends on ttlp_pkg and ttlp_axis_map.
`timescale 1ns / 1ps

// Usage
// Each input item is one poll of the touch panel: the touched flag, up to three
// raw samples with their valid flags and a millisecond timestamp. For every
// accepted item the block returns exactly one result item on the out_ channel:
// the gesture code (none, tap or long press) and the screen position of the
// most recent tap.
// A poll with usable samples runs both axes through a bit-serial mapper: an
// averaging division, a shift-add multiplication by the screen size and a
// division by the raw span, the same on both axes whatever the data. The
// result is then loaded into the output register, and the next item can be
// accepted in the cycle after that; the block takes no new poll while one is
// still in flight. A poll that does not count as touching skips the mapper:
// its result is loaded once the gesture is classified, and the next item can
// follow in the cycle after the load.
// The output register holds one result. If the receiver stalls, the next item
// is still accepted and processed, and its result waits until the output
// register is free; no further item is taken until then.
// The cfg_ port writes the calibration register named by cfg_index; writes are
// expected only while no item is in flight. Synchronous reset loads the default
// calibration, clears the gesture state and empties the output register.
module touch_tap_long_press_detector #(
  parameter int SAMPLES  = 3,
  parameter int RAW_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ttlp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ttlp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ttlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttlp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ttlp_pkg::*;

  // Raw readings are masked to RAW_BITS before they are summed.
  localparam logic [RAW_W-1:0] RAW_MASK = (RAW_BITS >= RAW_W) ? {RAW_W{1'b1}} :
                                          RAW_W'((32'd1 << RAW_BITS) - 32'd1);

  // Calibration registers.
  logic [RAW_W-1:0]   x_min_r, x_max_r, y_min_r, y_max_r;
  logic [RAW_W-1:0]   width_r, height_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= 12'd200;
      x_max_r  <= 12'd3800;
      y_min_r  <= 12'd200;
      y_max_r  <= 12'd3800;
      width_r  <= 12'd240;
      height_r <= 12'd320;
      limit_r  <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_RAW_MIN:     x_min_r  <= cfg_wdata[RAW_W-1:0];
        CFG_X_RAW_MAX:     x_max_r  <= cfg_wdata[RAW_W-1:0];
        CFG_Y_RAW_MIN:     y_min_r  <= cfg_wdata[RAW_W-1:0];
        CFG_Y_RAW_MAX:     y_max_r  <= cfg_wdata[RAW_W-1:0];
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata[RAW_W-1:0];
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata[RAW_W-1:0];
        CFG_LONG_LIMIT:    limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sample intake: sum the valid samples among the first SAMPLES of the poll.
  logic [RAW_W-1:0] smp_x [3];
  logic [RAW_W-1:0] smp_y [3];
  logic             smp_v [3];
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [CNT_W-1:0] cnt;
  logic             touching;

  always_comb begin
    smp_x[0] = in_data.sample0_x;
    smp_y[0] = in_data.sample0_y;
    smp_v[0] = in_data.sample0_valid;
    smp_x[1] = in_data.sample1_x;
    smp_y[1] = in_data.sample1_y;
    smp_v[1] = in_data.sample1_valid;
    smp_x[2] = in_data.sample2_x;
    smp_y[2] = in_data.sample2_y;
    smp_v[2] = in_data.sample2_valid;
    sum_x = '0;
    sum_y = '0;
    cnt   = '0;
    for (int k = 0; k < 3; k++) begin
      if (k < SAMPLES && smp_v[k]) begin
        sum_x = sum_x + {{(SUM_W-RAW_W){1'b0}}, smp_x[k] & RAW_MASK};
        sum_y = sum_y + {{(SUM_W-RAW_W){1'b0}}, smp_y[k] & RAW_MASK};
        cnt   = cnt + 1'b1;
      end
    end
    touching = in_data.first_touched && (cnt != '0);
  end

  // Control and gesture state.
  eng_state_t          state_r, state_nxt;
  logic                touch_r, touch_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic                pressed_r, pressed_nxt;
  logic                fired_r, fired_nxt;
  logic [PIX_W-1:0]    start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [PIX_W-1:0]    last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [TIME_W-1:0]   start_t_r, start_t_nxt;
  logic [PIX_W-1:0]    tap_x_r, tap_x_nxt, tap_y_r, tap_y_nxt;
  gesture_t            gest_r, gest_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                accept;
  logic                map_start;
  logic [PIX_W-1:0]    pix_x, pix_y;
  logic                done_x, done_y;
  logic [TIME_W-1:0]   held;
  logic [TIME_W-1:0]   limit32;

  assign accept    = in_valid && in_ready;
  assign map_start = accept && touching;
  assign in_ready  = (state_r == ENG_IDLE);
  assign held      = now_r - start_t_r;
  assign limit32   = {{(TIME_W-LIMIT_W){1'b0}}, limit_r};

  ttlp_axis_map u_map_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (map_start),
    .sum    (sum_x),
    .cnt    (cnt),
    .raw_lo (x_min_r),
    .raw_hi (x_max_r),
    .size   (width_r),
    .pix    (pix_x),
    .done   (done_x)
  );

  ttlp_axis_map u_map_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (map_start),
    .sum    (sum_y),
    .cnt    (cnt),
    .raw_lo (y_min_r),
    .raw_hi (y_max_r),
    .size   (height_r),
    .pix    (pix_y),
    .done   (done_y)
  );

  always_comb begin
    state_nxt     = state_r;
    touch_nxt     = touch_r;
    now_nxt       = now_r;
    pressed_nxt   = pressed_r;
    fired_nxt     = fired_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    start_t_nxt   = start_t_r;
    tap_x_nxt     = tap_x_r;
    tap_y_nxt     = tap_y_r;
    gest_nxt      = gest_r;
    out_data_nxt  = out_data_r;
    // The receiver drains the output register independently of the engine.
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ENG_IDLE: begin
        if (accept) begin
          touch_nxt = touching;
          now_nxt   = in_data.now_ms;
          state_nxt = touching ? ENG_MAP : ENG_CLS;
        end
      end
      ENG_MAP: begin
        // Both axes run in lockstep and finish in the same cycle.
        if (done_x && done_y) begin
          state_nxt = ENG_CLS;
        end
      end
      ENG_CLS: begin
        gest_nxt = GEST_NONE;
        if (!pressed_r) begin
          if (touch_r) begin
            pressed_nxt = 1'b1;
            start_x_nxt = pix_x;
            start_y_nxt = pix_y;
            last_x_nxt  = pix_x;
            last_y_nxt  = pix_y;
            start_t_nxt = now_r;
            fired_nxt   = 1'b0;
          end
        end else if (!touch_r) begin
          // Release: a short, steady hold is a tap unless a long press already fired.
          pressed_nxt = 1'b0;
          if (!fired_r && held < limit32
              && pix_abs_diff(last_x_r, start_x_r) < TAP_MOVE_LIMIT
              && pix_abs_diff(last_y_r, start_y_r) < TAP_MOVE_LIMIT) begin
            tap_x_nxt = start_x_r;
            tap_y_nxt = start_y_r;
            gest_nxt  = GEST_TAP;
          end
        end else begin
          // Still held: report a long press once when the limit is passed.
          last_x_nxt = pix_x;
          last_y_nxt = pix_y;
          if (!fired_r && held > limit32
              && pix_abs_diff(pix_x, start_x_r) < LONG_MOVE_LIMIT
              && pix_abs_diff(pix_y, start_y_r) < LONG_MOVE_LIMIT) begin
            fired_nxt = 1'b1;
            gest_nxt  = GEST_LONG;
          end
        end
        state_nxt = ENG_PUSH;
      end
      ENG_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.gesture = gest_r;
          out_data_nxt.tap_x   = tap_x_r;
          out_data_nxt.tap_y   = tap_y_r;
          state_nxt            = ENG_IDLE;
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      pressed_r   <= 1'b0;
      fired_r     <= 1'b0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      start_t_r   <= '0;
      tap_x_r     <= '0;
      tap_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pressed_r   <= pressed_nxt;
      fired_r     <= fired_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      start_t_r   <= start_t_nxt;
      tap_x_r     <= tap_x_nxt;
      tap_y_r     <= tap_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    touch_r    <= touch_nxt;
    now_r      <= now_nxt;
    gest_r     <= gest_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for touch_tap_long_press_detector: tap, long-press
// and tap-position prediction under several calibration settings.
// Depends on ttlp_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb;
  import ttlp_pkg::*;

  // The limit covers about 420 items, each taking the slowest path through the
  // block with a sender gap and receiver stalls, and allows several times that.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int POLLS_PER_PHASE = 64;

  // Gesture scoreboard. It holds its own copy of the calibration registers and
  // of the press tracker. It predicts one result item per accepted poll and
  // checks the results in order.
  class gesture_scoreboard;
    logic [RAW_W-1:0]   x_lo, x_hi, y_lo, y_hi, width_px, height_px;
    logic [LIMIT_W-1:0] hold_limit;
    bit                 finger_down, long_reported;
    logic [PIX_W-1:0]   down_x, down_y, cur_x, cur_y, tap_x, tap_y;
    logic [TIME_W-1:0]  down_ms;
    out_item_t          expected_q[$];
    int                 mismatches;

    function new();
      x_lo = 12'd200;
      x_hi = 12'd3800;
      y_lo = 12'd200;
      y_hi = 12'd3800;
      width_px = 12'd240;
      height_px = 12'd320;
      hold_limit = 16'd2000;
      finger_down = 1'b0;
      long_reported = 1'b0;
      down_x = '0;
      down_y = '0;
      cur_x = '0;
      cur_y = '0;
      tap_x = '0;
      tap_y = '0;
      down_ms = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_X_RAW_MIN:     x_lo = data[RAW_W-1:0];
        CFG_X_RAW_MAX:     x_hi = data[RAW_W-1:0];
        CFG_Y_RAW_MIN:     y_lo = data[RAW_W-1:0];
        CFG_Y_RAW_MAX:     y_hi = data[RAW_W-1:0];
        CFG_SCREEN_WIDTH:  width_px = data[RAW_W-1:0];
        CFG_SCREEN_HEIGHT: height_px = data[RAW_W-1:0];
        CFG_LONG_LIMIT:    hold_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Signed linear map with truncation toward zero, then clamp to the screen.
    function logic [PIX_W-1:0] to_pixel(int unsigned raw, int unsigned lo,
                                        int unsigned hi, int unsigned size);
      longint span, top, scaled;
      span = longint'(hi) - longint'(lo);
      if (size == 0) size = 1;
      top = longint'(size) - 1;
      if (top > longint'(PIX_MAX)) top = longint'(PIX_MAX);
      scaled = 0;
      if (span != 0) scaled = ((longint'(raw) - longint'(lo)) * longint'(size)) / span;
      if (scaled < 0) scaled = 0;
      if (scaled > top) scaled = top;
      return scaled[PIX_W-1:0];
    endfunction

    function logic [PIX_W-1:0] gap_px(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void note_poll(in_item_t p);
      int unsigned       sum_x, sum_y, n;
      logic [PIX_W-1:0]  px, py;
      logic [TIME_W-1:0] held;
      bit                touching;
      out_item_t         want;
      sum_x = 0;
      sum_y = 0;
      n = 0;
      px = '0;
      py = '0;
      touching = 1'b0;
      want.gesture = GEST_NONE;
      if (p.first_touched) begin
        if (p.sample0_valid) begin
          sum_x += 32'(p.sample0_x);
          sum_y += 32'(p.sample0_y);
          n++;
        end
        if (p.sample1_valid) begin
          sum_x += 32'(p.sample1_x);
          sum_y += 32'(p.sample1_y);
          n++;
        end
        if (p.sample2_valid) begin
          sum_x += 32'(p.sample2_x);
          sum_y += 32'(p.sample2_y);
          n++;
        end
        if (n != 0) begin
          touching = 1'b1;
          px = to_pixel(sum_x / n, 32'(x_lo), 32'(x_hi), 32'(width_px));
          py = to_pixel(sum_y / n, 32'(y_lo), 32'(y_hi), 32'(height_px));
        end
      end
      held = p.now_ms - down_ms;
      if (!finger_down) begin
        if (touching) begin
          finger_down = 1'b1;
          down_x = px;
          down_y = py;
          cur_x = px;
          cur_y = py;
          down_ms = p.now_ms;
          long_reported = 1'b0;
        end
      end else if (!touching) begin
        finger_down = 1'b0;
        if (!long_reported && held < {16'd0, hold_limit}
            && gap_px(cur_x, down_x) < TAP_MOVE_LIMIT
            && gap_px(cur_y, down_y) < TAP_MOVE_LIMIT) begin
          tap_x = down_x;
          tap_y = down_y;
          want.gesture = GEST_TAP;
        end
      end else begin
        cur_x = px;
        cur_y = py;
        if (!long_reported && held > {16'd0, hold_limit}
            && gap_px(cur_x, down_x) < LONG_MOVE_LIMIT
            && gap_px(cur_y, down_y) < LONG_MOVE_LIMIT) begin
          long_reported = 1'b1;
          want.gesture = GEST_LONG;
        end
      end
      want.tap_x = tap_x;
      want.tap_y = tap_y;
      expected_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result item with none expected: gesture %0d tap %0d,%0d",
                 $time, got.gesture, got.tap_x, got.tap_y);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.gesture !== want.gesture) begin
        $display("%0t: gesture expected %0d, actual %0d", $time, want.gesture, got.gesture);
        mismatches++;
      end
      if (got.tap_x !== want.tap_x) begin
        $display("%0t: tap_x expected %0d, actual %0d", $time, want.tap_x, got.tap_x);
        mismatches++;
      end
      if (got.tap_y !== want.tap_y) begin
        $display("%0t: tap_y expected %0d, actual %0d", $time, want.tap_y, got.tap_y);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gesture_scoreboard sb = new();

  // When quiet is set, neither side idles. The last phase runs this way.
  bit          quiet = 1'b0;
  int          polls_sent = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  logic [31:0] clock_ms = 32'd30000;

  touch_tap_long_press_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop. A hung handshake ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls in random bursts of random length. Between bursts
  // out_ready stays high, so stalls hit the block at every stage of its work.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each result item is checked at the edge that accepts it. The values are
  // sampled before that edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Builds a poll in which all three samples hold the same reading.
  function automatic in_item_t poll_at(bit touched, bit [2:0] vmask, logic [11:0] x,
                                       logic [11:0] y, logic [31:0] t);
    in_item_t p;
    p.first_touched = touched;
    p.sample0_valid = vmask[0];
    p.sample0_x = x;
    p.sample0_y = y;
    p.sample1_valid = vmask[1];
    p.sample1_x = x;
    p.sample1_y = y;
    p.sample2_valid = vmask[2];
    p.sample2_x = x;
    p.sample2_y = y;
    p.now_ms = t;
    return p;
  endfunction

  function automatic logic [11:0] near(logic [11:0] c, int jit);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic in_item_t random_poll();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  // A finger on the panel: at least one valid sample scattered around a center.
  function automatic in_item_t touch_poll(logic [11:0] cx, logic [11:0] cy, int jit,
                                          logic [31:0] t);
    in_item_t p;
    p = random_poll();
    p.first_touched = 1'b1;
    {p.sample2_valid, p.sample1_valid, p.sample0_valid} = 3'($urandom_range(1, 7));
    p.sample0_x = near(cx, jit);
    p.sample0_y = near(cy, jit);
    p.sample1_x = near(cx, jit);
    p.sample1_y = near(cy, jit);
    p.sample2_x = near(cx, jit);
    p.sample2_y = near(cy, jit);
    p.now_ms = t;
    return p;
  endfunction

  // Lift-off: either the touched flag is clear, or it is set but no sample
  // survived. Both count as not touching.
  function automatic in_item_t lift_poll(logic [31:0] t);
    in_item_t p;
    p = random_poll();
    if ($urandom_range(0, 1) == 0) begin
      p.first_touched = 1'b0;
    end else begin
      p.first_touched = 1'b1;
      p.sample0_valid = 1'b0;
      p.sample1_valid = 1'b0;
      p.sample2_valid = 1'b0;
    end
    p.now_ms = t;
    return p;
  endfunction

  // Offers one item. The valid stays high from one item to the next unless
  // an idle burst comes in between.
  task automatic offer_poll(input in_item_t p);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_poll(p);
    polls_sent++;
  endtask

  // Stops sending and waits until every expected result item has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // The upper nibble of a 12-bit register write is junk that the block must drop.
  function automatic logic [15:0] pad12(logic [11:0] v);
    return {4'($urandom_range(0, 15)), v};
  endfunction

  // Loads one calibration setting into every register while the block is idle.
  task automatic program_phase(input int which);
    logic [11:0] xlo, xhi, ylo, yhi, w, h;
    logic [15:0] lim;
    case (which)
      1: begin
        // A realistic panel with a random calibration.
        xlo = 12'($urandom_range(0, 800));
        xhi = 12'($urandom_range(3200, 4095));
        ylo = 12'($urandom_range(0, 800));
        yhi = 12'($urandom_range(3200, 4095));
        w = 12'($urandom_range(1, 2048));
        h = 12'($urandom_range(1, 2048));
        lim = 16'($urandom_range(200, 5000));
      end
      2: begin
        // Full raw span on x, a reversed y axis, the widest and narrowest
        // screens, and a zero hold limit, so no tap is possible.
        xlo = 12'd0;
        xhi = 12'd4095;
        ylo = 12'd4095;
        yhi = 12'd0;
        w = 12'd2048;
        h = 12'd1;
        lim = 16'd0;
      end
      3: begin
        // Equal min and max on x, a one-count span on y, a zero width, a
        // height above the pixel range, and the longest hold limit.
        xlo = 12'd2048;
        xhi = 12'd2048;
        ylo = 12'd0;
        yhi = 12'd1;
        w = 12'd0;
        h = 12'd4095;
        lim = 16'hFFFF;
      end
      4: begin
        xlo = 12'($urandom_range(0, 4095));
        xhi = 12'($urandom_range(0, 4095));
        ylo = 12'($urandom_range(0, 4095));
        yhi = 12'($urandom_range(0, 4095));
        w = 12'($urandom_range(0, 4095));
        h = 12'($urandom_range(0, 4095));
        lim = 16'($urandom_range(0, 65535));
      end
      default: begin
        xlo = 12'd100;
        xhi = 12'd4000;
        ylo = 12'd300;
        yhi = 12'd3900;
        w = 12'd800;
        h = 12'd480;
        lim = 16'd1000;
      end
    endcase
    drain();
    write_reg(CFG_X_RAW_MIN, pad12(xlo));
    write_reg(CFG_X_RAW_MAX, pad12(xhi));
    write_reg(CFG_Y_RAW_MIN, pad12(ylo));
    write_reg(CFG_Y_RAW_MAX, pad12(yhi));
    write_reg(CFG_SCREEN_WIDTH, pad12(w));
    write_reg(CFG_SCREEN_HEIGHT, pad12(h));
    write_reg(CFG_LONG_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  // Hand-picked polls under the reset calibration. There, a raw reading r
  // maps to (r - 200) * 240 / 3600 on x and (r - 200) * 320 / 3600 on y, and
  // the hold limit is 2000 ms.
  task automatic directed_polls();
    in_item_t p;
    // Idle: no touch, then touched with no valid sample.
    offer_poll(poll_at(1'b0, 3'b111, 12'hFFF, 12'hFFF, 32'd1000));
    offer_poll(poll_at(1'b1, 3'b000, 12'hFFF, 12'hFFF, 32'd1001));
    // Top raw readings clamp to the last pixel. A quick release gives a tap there.
    offer_poll(poll_at(1'b1, 3'b111, 12'hFFF, 12'hFFF, 32'd1010));
    offer_poll(poll_at(1'b0, 3'b111, 12'hFFF, 12'hFFF, 32'd1020));
    // Averaging truncates. y falls below min and clamps to zero. A hold past
    // the limit fires once, and the release after it stays silent.
    p = poll_at(1'b1, 3'b111, 12'hFFF, 12'd0, 32'd2000);
    p.sample2_x = 12'hFFE;
    p.sample1_y = 12'd1;
    p.sample2_y = 12'd2;
    offer_poll(p);
    p.now_ms = 32'd4001;
    offer_poll(p);
    p.now_ms = 32'd5000;
    offer_poll(p);
    offer_poll(poll_at(1'b0, 3'b000, 12'd0, 12'd0, 32'd5001));
    // Single-sample polls with junk in the invalid slots. A hold of exactly
    // the limit is neither a long press nor a tap.
    p = poll_at(1'b1, 3'b010, 12'd1000, 12'd1000, 32'd6000);
    p.sample0_x = 12'hFFF;
    p.sample2_y = 12'hABC;
    offer_poll(p);
    p = poll_at(1'b1, 3'b100, 12'd1150, 12'd1000, 32'd8000);
    p.sample1_x = 12'd7;
    offer_poll(p);
    offer_poll(poll_at(1'b0, 3'b111, 12'd0, 12'd0, 32'd8000));
    // A move of 30 pixels still counts as a tap. A move of 50 pixels does not.
    offer_poll(poll_at(1'b1, 3'b001, 12'd1000, 12'd1000, 32'd9000));
    offer_poll(poll_at(1'b1, 3'b001, 12'd1450, 12'd1000, 32'd9010));
    offer_poll(poll_at(1'b0, 3'b001, 12'd1450, 12'd1000, 32'd9020));
    offer_poll(poll_at(1'b1, 3'b011, 12'd1000, 12'd1000, 32'd9100));
    offer_poll(poll_at(1'b1, 3'b011, 12'd1750, 12'd1000, 32'd9110));
    offer_poll(poll_at(1'b1, 3'b000, 12'd1750, 12'd1000, 32'd9120));
    // A drift of exactly 20 pixels blocks the long press. Coming back to the
    // start point lets it fire late.
    offer_poll(poll_at(1'b1, 3'b111, 12'd1000, 12'd1000, 32'd9200));
    offer_poll(poll_at(1'b1, 3'b111, 12'd1300, 12'd1000, 32'd11300));
    offer_poll(poll_at(1'b1, 3'b111, 12'd1000, 12'd1000, 32'd11400));
    offer_poll(poll_at(1'b0, 3'b111, 12'd1000, 12'd1000, 32'd11500));
    // The timestamp wraps in the middle of a short tap at the screen origin.
    offer_poll(poll_at(1'b1, 3'b111, 12'd200, 12'd200, 32'hFFFF_FFF0));
    offer_poll(poll_at(1'b0, 3'b111, 12'd200, 12'd200, 32'h0000_0010));
    // A hold one millisecond short of the limit is still a tap.
    offer_poll(poll_at(1'b1, 3'b111, 12'd3800, 12'd3800, 32'd20000));
    offer_poll(poll_at(1'b0, 3'b111, 12'd3800, 12'd3800, 32'd21999));
  endtask

  // One touch: a press, a few held polls around a center with a chosen amount
  // of jitter, and usually a release. The time steps scale with the current
  // hold limit, so both short and long holds occur.
  task automatic run_episode();
    logic [11:0] cx, cy;
    int          jit, holds, step_max, i;
    cx = 12'($urandom_range(0, 4095));
    cy = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 3))
      0: jit = 0;
      1: jit = 30;
      2: jit = 250;
      default: jit = 1200;
    endcase
    holds = $urandom_range(0, 6);
    step_max = int'(sb.hold_limit) / 3 + 20;
    if ($urandom_range(0, 9) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 4);
    offer_poll(touch_poll(cx, cy, jit, clock_ms));
    for (i = 0; i < holds; i++) begin
      clock_ms += $urandom_range(0, step_max);
      offer_poll(touch_poll(cx, cy, jit, clock_ms));
    end
    if ($urandom_range(0, 6) != 0) begin
      clock_ms += $urandom_range(0, step_max);
      offer_poll(lift_poll(clock_ms));
    end
  endtask

  // Mostly well-formed touches. Now and then a fully random poll breaks into them.
  task automatic random_polls(input int count);
    int target;
    target = polls_sent + count;
    while (polls_sent < target) begin
      if ($urandom_range(0, 9) == 0) offer_poll(random_poll());
      else run_episode();
    end
  endtask

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    directed_polls();
    random_polls(POLLS_PER_PHASE);
    for (phase = 1; phase <= 5; phase++) begin
      // Each change of setting first waits for the block to drain.
      if (phase == 5) quiet = 1'b1;
      program_phase(phase);
      random_polls(POLLS_PER_PHASE);
    end
    drain();
    // Wait a little longer, in case the block sends result items nobody asked for.
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ttlp_pkg.sv
rtl/ttlp_axis_map.sv
rtl/touch_tap_long_press_detector.sv
tb/sv/tb.sv
